[design/csem_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csem_pkg
// Shared types and codes for the counting semaphore table: request and
// response words, action and status codes, flags of the count unit.
// ----------------------------------------------------------------------------
package csem_pkg;

	// default sizes handed to the top level
	localparam int NUM_SLOTS_DEF   = 256;
	localparam int COUNT_WIDTH_DEF = 16;

	// action codes, the fourth code is unused and answered with an error
	localparam logic [1:0] ACT_CREATE = 2'd0;
	localparam logic [1:0] ACT_WAIT   = 2'd1;
	localparam logic [1:0] ACT_SIGNAL = 2'd2;
	localparam logic [1:0] ACT_UNUSED = 2'd3;

	// status codes
	localparam logic STATUS_OK  = 1'b0;
	localparam logic STATUS_ERR = 1'b1;

	// request word
	typedef struct packed {
		logic [1:0]         action;
		logic [7:0]         sem_index;
		logic signed [15:0] initial_count;
	} csem_req_t;

	// response word
	typedef struct packed {
		logic       status;
		logic [7:0] slot_out;
		logic       blocked;
		logic       wake;
	} csem_rsp_t;

	// flags from the count unit
	typedef struct packed {
		logic at_limit;
		logic blocked;
		logic wake;
	} csem_flags_t;

endpackage
`default_nettype wire

[design/counting_semaphore_table.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// counting_semaphore_table
// Table of counting semaphores with create, wait (P) and signal (V).
// ----------------------------------------------------------------------------
// Each request word gives exactly one response word. After acceptance an
// operation passes the lookup and execute states, and req_ready is low
// meanwhile: lookup reads the slot's count from the single-port count memory,
// execute runs it through the shared count unit, writes it back and loads the
// response register. req_ready returns once that register is loaded, so a new
// word is taken only after the last one is through; a response still waiting for
// rsp_ready holds the block in its last step until that response is taken.
// Slots are handed out lowest first and never
// freed, so a fill count stands for the valid bits; there is no clearing pass
// after reset. A create answers with the slot index (its low eight bits), a
// wait raises blocked when the count drops below zero, a signal raises wake
// when the new count is zero or less. Errors give status 1 with all else zero.
// ----------------------------------------------------------------------------
module counting_semaphore_table #(
	parameter int NUM_SLOTS   = csem_pkg::NUM_SLOTS_DEF,
	parameter int COUNT_WIDTH = csem_pkg::COUNT_WIDTH_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 req_valid,
	output logic                      req_ready,
	input  wire csem_pkg::csem_req_t  req_data,
	output logic                      rsp_valid,
	input  wire logic                 rsp_ready,
	output csem_pkg::csem_rsp_t       rsp_data
);
	import csem_pkg::*;

	localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int FILL_W = SLOT_W + 1;
	localparam int CMP_W  = (FILL_W > 8) ? FILL_W : 8;

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_LOOKUP = 3'b010,
		ST_EXEC   = 3'b100
	} state_t;

	state_t                         st_q;
	logic [FILL_W-1:0]              fill_q;
	logic [1:0]                     action_q;
	logic                           pre_err_q;
	logic [SLOT_W-1:0]              addr_q;
	logic [COUNT_WIDTH-1:0]         init_q;
	logic signed [COUNT_WIDTH-1:0]  rd_q;
	logic [COUNT_WIDTH-1:0]         mem_q [NUM_SLOTS];
	logic                           rsp_valid_q;
	csem_rsp_t                      rsp_q;

	logic                           req_fire;
	logic [CMP_W-1:0]               idx_ext;
	logic [CMP_W-1:0]               fill_ext;
	logic                           slot_ok;
	logic                           init_bad;
	logic                           full;
	logic                           pre_err;
	logic [SLOT_W-1:0]              addr_next;
	logic [COUNT_WIDTH+15:0]        init_wide;
	logic [SLOT_W+7:0]              slot_wide;
	logic                           rsp_load;
	logic                           wr_en;
	logic                           fill_inc;
	logic [COUNT_WIDTH-1:0]         wr_data;
	csem_rsp_t                      rsp_next;
	logic signed [COUNT_WIDTH-1:0]  alu_sum;
	csem_flags_t                    alu_flags;

	assign req_ready = (st_q == ST_IDLE);
	assign req_fire  = req_valid && req_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;
	assign rsp_load  = (st_q == ST_EXEC) && (!rsp_valid_q || rsp_ready);

	// checks decided on the request word, against the fill count
	always_comb begin
		idx_ext   = CMP_W'(req_data.sem_index);
		fill_ext  = CMP_W'(fill_q);
		slot_ok   = idx_ext < fill_ext;
		init_bad  = req_data.initial_count[15]
			|| ((req_data.initial_count[14:0] >> (COUNT_WIDTH - 1)) != 15'd0);
		full      = (fill_q == FILL_W'(NUM_SLOTS));
		init_wide = {{COUNT_WIDTH{1'b0}}, req_data.initial_count};
		case (req_data.action) inside
			ACT_CREATE:             pre_err = init_bad || full;
			ACT_WAIT, ACT_SIGNAL:   pre_err = !slot_ok;
			default:                pre_err = 1'b1;
		endcase
		if (pre_err) begin
			addr_next = '0;
		end else if (req_data.action == ACT_CREATE) begin
			addr_next = fill_q[SLOT_W-1:0];
		end else begin
			addr_next = idx_ext[SLOT_W-1:0];
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
		end else begin
			unique case (st_q)
				ST_IDLE:   if (req_fire) st_q <= ST_LOOKUP;
				ST_LOOKUP: st_q <= ST_EXEC;
				ST_EXEC:   if (rsp_load) st_q <= ST_IDLE;
				default:   st_q <= ST_IDLE;
			endcase
		end
	end

	// latched request
	always_ff @(posedge clk) begin
		if (req_fire) begin
			action_q  <= req_data.action;
			pre_err_q <= pre_err;
			addr_q    <= addr_next;
			init_q    <= init_wide[COUNT_WIDTH-1:0];
		end
	end

	// count memory, one access a cycle
	always_ff @(posedge clk) begin
		if (st_q == ST_LOOKUP) begin
			rd_q <= mem_q[addr_q];
		end
		if (wr_en) begin
			mem_q[addr_q] <= wr_data;
		end
	end

	csem_alu #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_alu (
		.count (rd_q),
		.incr  (action_q == ACT_SIGNAL),
		.sum   (alu_sum),
		.flags (alu_flags)
	);

	// outcome of the operation and write back
	always_comb begin
		slot_wide = {8'd0, addr_q};
		rsp_next  = '0;
		wr_en     = 1'b0;
		fill_inc  = 1'b0;
		wr_data   = init_q;
		if (pre_err_q) begin
			rsp_next.status = STATUS_ERR;
		end else if (action_q == ACT_CREATE) begin
			rsp_next.status   = STATUS_OK;
			rsp_next.slot_out = slot_wide[7:0];
			wr_en             = rsp_load;
			fill_inc          = rsp_load;
		end else if (alu_flags.at_limit) begin
			rsp_next.status = STATUS_ERR;
		end else begin
			rsp_next.status  = STATUS_OK;
			rsp_next.blocked = alu_flags.blocked;
			rsp_next.wake    = alu_flags.wake;
			wr_en            = rsp_load;
			wr_data          = alu_sum;
		end
	end

	// fill count stands for the valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (fill_inc) begin
			fill_q <= fill_q + 1'b1;
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_q <= rsp_next;
		end
	end

	// checks
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(NUM_SLOTS))
		else $error("fill count beyond table size");

	a_fill_step: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q != $past(fill_q)) |-> (fill_q == $past(fill_q) + 1'b1))
		else $error("fill count moved by more than one");

	a_accept_lookup: assert property (@(posedge clk) disable iff (!arst_n)
		req_fire |=> (st_q == ST_LOOKUP))
		else $error("accepted word not looked up");

	a_rsp_flags: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> !(rsp_q.blocked && rsp_q.wake)
			&& !(rsp_q.status == STATUS_ERR && (rsp_q.blocked || rsp_q.wake)))
		else $error("inconsistent response flags");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_load |-> (!rsp_valid_q || rsp_ready))
		else $error("response overwritten");

endmodule
`default_nettype wire

[design/csem_alu.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csem_alu
// Shared count unit: one adder that steps a count up or down by one, with
// the limit compare on the old count and the blocked and wake decisions on the new count.
// ----------------------------------------------------------------------------
module csem_alu #(
	parameter int COUNT_WIDTH = csem_pkg::COUNT_WIDTH_DEF
) (
	input  wire logic signed [COUNT_WIDTH-1:0] count,
	input  wire logic                          incr,
	output logic signed [COUNT_WIDTH-1:0]      sum,
	output csem_pkg::csem_flags_t              flags
);
	import csem_pkg::*;

	localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
	localparam logic [COUNT_WIDTH-1:0] CNT_MIN = {1'b1, {(COUNT_WIDTH-1){1'b0}}};
	localparam logic [COUNT_WIDTH-1:0] STEP_UP = {{(COUNT_WIDTH-1){1'b0}}, 1'b1};
	localparam logic [COUNT_WIDTH-1:0] STEP_DN = {COUNT_WIDTH{1'b1}};

	// plus or minus one through a single adder
	always_comb begin
		sum = count + $signed(incr ? STEP_UP : STEP_DN);
	end

	// limit check on the old count, sign tests on the new one
	always_comb begin
		flags.at_limit = incr ? (count == $signed(CNT_MAX)) : (count == $signed(CNT_MIN));
		flags.blocked  = !incr && sum[COUNT_WIDTH-1];
		flags.wake     = incr && (sum[COUNT_WIDTH-1] || (sum == '0));
	end

endmodule
`default_nettype wire

[sim/tb_counting_semaphore_table.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_counting_semaphore_table
// Self-checking bench for the counting semaphore table. A driver streams
// request words in random bursts, a sink stalls the response side, and a
// shadow copy of the slot table predicts every response word, which is
// compared field by field as it leaves the block.
// ----------------------------------------------------------------------------
module tb_counting_semaphore_table;
	import csem_pkg::*;

	localparam int NUM_SLOTS   = NUM_SLOTS_DEF;
	localparam int COUNT_WIDTH = COUNT_WIDTH_DEF;
	localparam int CNT_MAX     = (1 << (COUNT_WIDTH - 1)) - 1;
	localparam int CNT_MIN     = -CNT_MAX - 1;
	localparam int RAND_WORDS  = 700;
	// cycle limit for ~720 words, with headroom
	localparam int LIMIT       = 200_000;

	typedef enum logic [1:0] {SINK_OPEN, SINK_RANDOM, SINK_PERIODIC} sink_mode_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_ready;
	csem_req_t req_data = '0;
	logic      rsp_valid;
	logic      rsp_ready = 1'b0;
	csem_rsp_t rsp_data;

	// shadow of the slot table
	logic slot_live [NUM_SLOTS];
	int   slot_level [NUM_SLOTS];
	int   n_made = 0;

	csem_req_t  req_backlog [$];
	csem_rsp_t  rsp_due [$];
	int         errors = 0;
	int         cycle_count = 0;
	logic       req_took = 1'b0;
	int         burst_left = 1;
	int         gap_left = 0;
	sink_mode_t sink_mode = SINK_OPEN;
	int         sink_hold = 0;

	counting_semaphore_table DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_data  (rsp_data)
	);

	always #6 clk = ~clk;

	// response word the table owes for one request, updates the shadow
	function automatic csem_rsp_t semaphore_outcome(input csem_req_t req);
		csem_rsp_t r;
		int        i;
		int        cnt;
		logic      placed;
		r = '0;
		r.status = STATUS_ERR;
		placed = 1'b0;
		case (req.action) inside
			ACT_CREATE: begin
				if (req.initial_count >= 0 && int'(req.initial_count) <= CNT_MAX) begin
					for (i = 0; i < NUM_SLOTS && !placed; i++) begin
						if (!slot_live[i]) begin
							slot_live[i] = 1'b1;
							slot_level[i] = req.initial_count;
							r.status = STATUS_OK;
							r.slot_out = i[7:0];
							placed = 1'b1;
						end
					end
				end
			end
			ACT_WAIT, ACT_SIGNAL: begin
				if (int'(req.sem_index) < NUM_SLOTS && slot_live[req.sem_index]) begin
					cnt = slot_level[req.sem_index];
					if (req.action == ACT_WAIT && cnt > CNT_MIN) begin
						cnt = cnt - 1;
						slot_level[req.sem_index] = cnt;
						r.status = STATUS_OK;
						r.blocked = (cnt < 0);
					end else if (req.action == ACT_SIGNAL && cnt < CNT_MAX) begin
						cnt = cnt + 1;
						slot_level[req.sem_index] = cnt;
						r.status = STATUS_OK;
						r.wake = (cnt <= 0);
					end
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			errors++;
			$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endtask

	// append a request word, tracking how many slots it will have claimed
	task automatic queue_req(input logic [1:0] action, input logic [7:0] idx,
	                         input logic signed [15:0] init);
		csem_req_t w;
		w.action = action;
		w.sem_index = idx;
		w.initial_count = init;
		if (action == ACT_CREATE && init >= 0 && n_made < NUM_SLOTS)
			n_made++;
		req_backlog.push_back(w);
	endtask

	// random word: mostly operations on live slots, creates often until the table fills and rarely after
	task automatic queue_random_req();
		int               pick;
		logic [1:0]       action;
		logic [7:0]       idx;
		logic signed [15:0] init;
		pick = $urandom_range(0, 99);
		if (pick < ((n_made < NUM_SLOTS) ? 55 : 10))
			action = ACT_CREATE;
		else if (pick < 95)
			action = ($urandom_range(0, 1) == 0) ? ACT_WAIT : ACT_SIGNAL;
		else
			action = ACT_UNUSED;
		if (n_made > 0 && $urandom_range(0, 9) < 8)
			idx = 8'($urandom_range(0, n_made - 1));
		else
			idx = 8'($urandom_range(0, 255));
		pick = $urandom_range(0, 99);
		if (action != ACT_CREATE || pick < 10)
			init = 16'($urandom);
		else if (pick < 15)
			init = 16'(CNT_MAX);
		else if (pick < 30)
			init = 16'($urandom_range(0, CNT_MAX));
		else
			init = 16'($urandom_range(0, 3));
		queue_req(action, idx, init);
	endtask

	// block until every queued word is accepted and answered
	task automatic wait_quiet();
		do
			@(posedge clk);
		while (req_backlog.size() != 0 || req_valid || rsp_due.size() != 0);
	endtask

	// cycle limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// request driver, bursts with random gaps
	always @(negedge clk) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else if (!req_valid || req_took) begin
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				req_valid <= 1'b0;
			end else if (req_backlog.size() != 0) begin
				req_data <= req_backlog.pop_front();
				req_valid <= 1'b1;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 16);
					gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// response sink, switches stall pattern now and then
	always @(negedge clk) begin
		if (sink_hold == 0) begin
			sink_mode <= sink_mode_t'($urandom_range(0, 2));
			sink_hold <= $urandom_range(20, 150);
		end else begin
			sink_hold <= sink_hold - 1;
		end
		case (sink_mode)
			SINK_OPEN:   rsp_ready <= 1'b1;
			SINK_RANDOM: rsp_ready <= 1'($urandom_range(0, 1));
			default:     rsp_ready <= (cycle_count % 4 == 0);
		endcase
	end

	// monitor: predict on request accept, check on response accept
	always @(posedge clk) begin : monitor
		csem_rsp_t want;
		req_took <= arst_n && req_valid && req_ready;
		if (arst_n) begin
			if (req_valid && req_ready)
				rsp_due.push_back(semaphore_outcome(req_data));
			if (rsp_valid && rsp_ready) begin
				if (rsp_due.size() == 0) begin
					errors++;
					$display("%0t ns: unexpected response word, expected none, actual %h",
					         $time, rsp_data);
				end else begin
					want = rsp_due.pop_front();
					check_field("status", int'(want.status), int'(rsp_data.status));
					check_field("slot_out", int'(want.slot_out), int'(rsp_data.slot_out));
					check_field("blocked", int'(want.blocked), int'(rsp_data.blocked));
					check_field("wake", int'(want.wake), int'(rsp_data.wake));
				end
			end
		end
	end

	initial begin
		int i;
		for (i = 0; i < NUM_SLOTS; i++) begin
			slot_live[i] = 1'b0;
			slot_level[i] = 0;
		end
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: bad slots on an empty table, rejected creates
		queue_req(ACT_WAIT, 8'd5, 16'sd0);
		queue_req(ACT_SIGNAL, 8'd255, -16'sd1);
		queue_req(ACT_CREATE, 8'd0, -16'sd1);
		queue_req(ACT_CREATE, 8'd255, -16'sd32768);
		// slot 0 at zero, slot 1 at the top, slot 2 at one
		queue_req(ACT_CREATE, 8'd255, 16'sd0);
		queue_req(ACT_CREATE, 8'd0, 16'sd32767);
		queue_req(ACT_CREATE, 8'd170, 16'sd1);
		// block and wake around zero
		queue_req(ACT_WAIT, 8'd0, -16'sd32768);
		queue_req(ACT_SIGNAL, 8'd0, 16'sd32767);
		queue_req(ACT_SIGNAL, 8'd0, 16'sd0);
		queue_req(ACT_WAIT, 8'd0, 16'sd0);
		// signal at the top of the count range
		queue_req(ACT_SIGNAL, 8'd1, 16'sd0);
		queue_req(ACT_WAIT, 8'd1, 16'sd0);
		queue_req(ACT_SIGNAL, 8'd1, 16'sd0);
		queue_req(ACT_SIGNAL, 8'd1, 16'sd0);
		// unused action code, then waits and a signal on slot 2 and a wait on an unmade slot
		queue_req(ACT_UNUSED, 8'd0, 16'sd0);
		queue_req(ACT_UNUSED, 8'd255, -16'sd1);
		queue_req(ACT_WAIT, 8'd2, 16'sd0);
		queue_req(ACT_WAIT, 8'd2, 16'sd0);
		queue_req(ACT_SIGNAL, 8'd2, 16'sd0);
		queue_req(ACT_WAIT, 8'd3, 16'sd0);
		wait_quiet();

		// random traffic in two halves with a full drain in between
		for (i = 0; i < RAND_WORDS / 2; i++)
			queue_random_req();
		wait_quiet();
		for (i = 0; i < RAND_WORDS / 2; i++)
			queue_random_req();
		wait_quiet();

		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

[counting_semaphore_table.f]
design/csem_pkg.sv
design/csem_alu.sv
design/counting_semaphore_table.sv
sim/tb_counting_semaphore_table.sv
